FILE: sv/lkvc_pkg.sv
// Package for the LRU key/value cache core: field widths, operation and status codes,
// and the packed request and response types.
// No dependencies.
package lkvc_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_GET_MISS     = 3'd0,
    ST_GET_HIT      = 3'd1,
    ST_PUT_UPDATE   = 3'd2,
    ST_PUT_INSERT   = 3'd3,
    ST_PUT_EVICT    = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [KEY_W-1:0]  key;
    logic [DATA_W-1:0]        value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [DATA_W-1:0]        read_data;
    logic signed [KEY_W-1:0]  evicted_key;
  } rsp_t;

endpackage

FILE: sv/lru_key_value_cache_core.sv
// LRU key/value cache core: fully associative store with parallel key compare,
// recency ranks and least-recently-used eviction.
// Depends on lkvc_pkg.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one get or put item per transfer.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per item,
//   in order. cfg channel (cfg_valid / cfg_ready / cfg_data) writes the capacity
//   register; cfg_ready is always high. Write capacity only while the core is idle.
//   Path: a request is captured in the input register, looked up from there, and its
//   result is captured in the result register, which drives rsp_valid. Throughput is
//   one item per cycle while rsp_stall is low: all key compares, the hit
//   and victim selects and the rank update sit in one combinational pass between
//   the input register and the result register, and state is updated at the same
//   edge, so the next item always sees it.
//   When the receiver holds rsp_stall, the result register keeps its item, the
//   input register fills and then req_stall is raised.
//   Reset (rst, synchronous) empties the cache, sets capacity to 16 and drops
//   any item in flight.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0]    capacity;
  logic                s1_valid;
  req_t                s1;
  logic [KEY_W-1:0]    key_store  [ENTRIES];
  logic [DATA_W-1:0]   data_store [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid;
  logic [RANK_W-1:0]   rank       [ENTRIES];
  logic [OCC_W-1:0]    occupancy;

  logic                advance;
  logic                do_step;
  logic [ENTRIES-1:0]  hit_vec;
  logic                any_hit;
  logic [RANK_W-1:0]   hit_rank;
  logic [DATA_W-1:0]   hit_data;
  logic [CMP_W-1:0]    cap_x;
  logic [CMP_W-1:0]    cap_eff;
  logic                evict;
  logic [RANK_W-1:0]   last_rank;
  logic [ENTRIES-1:0]  victim_vec;
  logic [KEY_W-1:0]    victim_key;
  logic [ENTRIES-1:0]  valid_after;
  logic [ENTRIES-1:0]  slot_vec;
  logic                promote;
  logic                insert;
  logic [ENTRIES-1:0]  valid_next;
  logic [RANK_W-1:0]   rank_next  [ENTRIES];
  logic [OCC_W-1:0]    occupancy_next;
  logic [ENTRIES-1:0]  key_we;
  logic [ENTRIES-1:0]  data_we;
  rsp_t                rsp_next;

  assign cfg_ready = 1'b1;
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign do_step   = s1_valid && advance;

  // lookup: keys are unique among valid entries, so hit and victim are one-hot
  always_comb begin
    hit_rank   = '0;
    hit_data   = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (key_store[i] == s1.key);
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank[i];
        hit_data = hit_data | data_store[i];
      end
    end
    any_hit = |hit_vec;

    cap_x = CMP_W'(capacity);
    if (cap_x == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_x > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_x;
    end

    promote = any_hit;
    insert  = (s1.kind == KIND_PUT) && !any_hit;
    evict   = insert && (CMP_W'(occupancy) >= cap_eff);

    // least recent valid entry holds rank occupancy-1
    last_rank = RANK_W'(occupancy - OCC_W'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = entry_valid[i] && (rank[i] == last_rank);
      if (victim_vec[i]) begin
        victim_key = victim_key | key_store[i];
      end
    end

    valid_after = evict ? (entry_valid & ~victim_vec) : entry_valid;
    // lowest free entry
    slot_vec    = ~valid_after & (valid_after + ENTRIES'(1));
  end

  always_comb begin
    valid_next     = entry_valid;
    occupancy_next = occupancy;
    key_we         = '0;
    data_we        = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
    end
    rsp_next.status      = ST_GET_MISS;
    rsp_next.read_data   = '0;
    rsp_next.evicted_key = '0;

    if (promote) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_vec[i]) begin
          rank_next[i] = '0;
        end else if (entry_valid[i] && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end
      end
      if (s1.kind == KIND_PUT) begin
        rsp_next.status = ST_PUT_UPDATE;
        data_we         = hit_vec;
      end else begin
        rsp_next.status    = ST_GET_HIT;
        rsp_next.read_data = hit_data;
      end
    end else if (insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_vec[i]) begin
          rank_next[i] = '0;
        end else if (valid_after[i]) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end
      end
      valid_next = valid_after | slot_vec;
      key_we     = slot_vec;
      data_we    = slot_vec;
      if (evict) begin
        rsp_next.status      = ST_PUT_EVICT;
        rsp_next.evicted_key = victim_key;
      end else begin
        rsp_next.status = ST_PUT_INSERT;
        occupancy_next  = occupancy + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      s1_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (!req_stall) begin
        s1_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
      if (do_step) begin
        entry_valid <= valid_next;
        occupancy   <= occupancy_next;
        for (int i = 0; i < ENTRIES; i++) begin
          rank[i] <= rank_next[i];
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
    if (do_step) begin
      rsp <= rsp_next;
      for (int i = 0; i < ENTRIES; i++) begin
        if (key_we[i]) begin
          key_store[i] <= s1.key;
        end
        if (data_we[i]) begin
          data_store[i] <= s1.value;
        end
      end
    end
  end

endmodule
